[rtl/core/edr_pkg.sv]
// ----------------------------------------------------------------------------
// edr_pkg: shared types and constants
// Field widths, register codes and controller/datapath handshake structs.
// ----------------------------------------------------------------------------
`default_nettype none

package edr_pkg;

    localparam int INDEX_WIDTH     = 8;
    localparam int ELEM_WIDTH      = 16;
    localparam int DIST_WIDTH      = 20;
    localparam int SUM_WIDTH       = 40;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 8;

    // one result bit per root step
    localparam int ROOT_STEPS      = DIST_WIDTH;
    localparam int STEP_WIDTH      = $clog2(ROOT_STEPS);

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_FIRST_INDEX = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LAST_INDEX  = 2'd1;

    localparam logic [INDEX_WIDTH-1:0] FIRST_INDEX_RESET = 8'd0;
    localparam logic [INDEX_WIDTH-1:0] LAST_INDEX_RESET  = 8'd255;

    typedef struct packed {
        logic root_run;
        logic out_load;
    } edr_cmd_t;

    typedef struct packed {
        logic sum_done;
        logic root_done;
    } edr_status_t;

endpackage

`default_nettype wire

[rtl/core/edr_ifs.sv]
// ----------------------------------------------------------------------------
// edr_ifs: channel interfaces
// Pair input, result output and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface edr_pair_if
    import edr_pkg::*;
;
    logic                          valid;
    logic                          ready;
    logic [INDEX_WIDTH-1:0]        element_index;
    logic signed [ELEM_WIDTH-1:0]  left_element;
    logic signed [ELEM_WIDTH-1:0]  right_element;
    logic                          end_of_vector;

    modport source (output valid, element_index, left_element, right_element,
                    end_of_vector, input ready);
    modport sink   (input valid, element_index, left_element, right_element,
                    end_of_vector, output ready);
endinterface

interface edr_result_if
    import edr_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [DIST_WIDTH-1:0] distance;
    logic [SUM_WIDTH-1:0]  squared_sum;

    modport source (output valid, distance, squared_sum, input ready);
    modport sink   (input valid, distance, squared_sum, output ready);
endinterface

interface edr_cfg_if
    import edr_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic [CFG_INDEX_WIDTH-1:0] index;
    logic [CFG_DATA_WIDTH-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/core/edr_ctrl.sv]
// ----------------------------------------------------------------------------
// edr_ctrl: sequencing controller
// Gates pair intake, runs the root iterations and owns the result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module edr_ctrl
    import edr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        pair_valid,
    output logic             pair_ready,
    input  wire logic        pair_last,
    output logic             out_valid,
    input  wire logic        out_ready,
    input  wire edr_status_t status,
    output edr_cmd_t         cmd
);

    localparam logic [1:0] ST_ACCUM  = 2'd0;
    localparam logic [1:0] ST_WAIT   = 2'd1;
    localparam logic [1:0] ST_ROOT   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free   = !out_valid_reg || out_ready;
    assign pair_ready = (state_reg == ST_ACCUM);
    assign out_valid  = out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        cmd.root_run = 1'b0;
        cmd.out_load = 1'b0;
        case (state_reg)
            ST_ACCUM:
            begin
                if (pair_valid && pair_last)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (status.sum_done)
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                cmd.root_run = 1'b1;
                if (status.root_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCUM;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/edr_datapath.sv]
// ----------------------------------------------------------------------------
// edr_datapath: difference, square, accumulate and root datapath
// Window registers, squaring pipeline, saturating sum, bit-serial square root.
// ----------------------------------------------------------------------------
`default_nettype none

module edr_datapath
    import edr_pkg::*;
#(
    parameter int MAX_DIM       = 256,
    parameter int ELEMENT_WIDTH = 16
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        pair_fire,
    input  wire logic [INDEX_WIDTH-1:0]      element_index,
    input  wire logic [ELEM_WIDTH-1:0]       left_element,
    input  wire logic [ELEM_WIDTH-1:0]       right_element,
    input  wire logic                        end_of_vector,
    input  wire logic                        cfg_fire,
    input  wire logic [CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]   cfg_data,
    input  wire edr_cmd_t                    cmd,
    output edr_status_t                      status,
    output logic [DIST_WIDTH-1:0]            distance,
    output logic [SUM_WIDTH-1:0]             squared_sum
);

    localparam int MAG_WIDTH = ELEMENT_WIDTH + 1;
    localparam int SQ_WIDTH  = 2 * MAG_WIDTH;
    localparam int REM_WIDTH = DIST_WIDTH + 2;
    localparam logic [INDEX_WIDTH:0] INDEX_LIMIT = (INDEX_WIDTH + 1)'(MAX_DIM);
    localparam logic [SUM_WIDTH-1:0] SUM_MAX = {SUM_WIDTH{1'b1}};

    // window registers
    logic [INDEX_WIDTH-1:0] first_index_reg, last_index_reg;

    // squaring pipeline
    logic signed [MAG_WIDTH-1:0] diff;
    logic [MAG_WIDTH-1:0]        mag;
    logic                        in_window;
    logic [MAG_WIDTH-1:0]        mag_reg, mag_next;
    logic                        mag_end_reg;
    logic [SQ_WIDTH-1:0]         sq_reg;
    logic                        sq_end_reg;

    // accumulator
    logic [SUM_WIDTH:0]          sum_wide;
    logic [SUM_WIDTH-1:0]        sum_sat;
    logic [SUM_WIDTH-1:0]        acc_reg;
    logic [SUM_WIDTH-1:0]        root_work_reg;

    // square root
    logic [STEP_WIDTH-1:0]       step_reg;
    logic [REM_WIDTH-1:0]        rem_reg;
    logic [DIST_WIDTH-1:0]       root_reg;
    logic [1:0]                  digit;
    logic [REM_WIDTH+1:0]        rem_shift;
    logic [REM_WIDTH+1:0]        trial;
    logic                        take;

    logic [DIST_WIDTH-1:0]       distance_reg;
    logic [SUM_WIDTH-1:0]        squared_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_index_reg <= FIRST_INDEX_RESET;
            last_index_reg  <= LAST_INDEX_RESET;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                REG_FIRST_INDEX: first_index_reg <= cfg_data;
                REG_LAST_INDEX:  last_index_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // use only the low ELEMENT_WIDTH bits of each element, as two's complement
    assign diff = $signed({left_element[ELEMENT_WIDTH-1], left_element[ELEMENT_WIDTH-1:0]})
                - $signed({right_element[ELEMENT_WIDTH-1], right_element[ELEMENT_WIDTH-1:0]});
    assign mag  = diff[MAG_WIDTH-1] ? MAG_WIDTH'(-diff) : MAG_WIDTH'(diff);

    assign in_window = (element_index >= first_index_reg)
                    && (element_index <= last_index_reg)
                    && ({1'b0, element_index} < INDEX_LIMIT);

    // zero magnitude adds nothing, so idle cycles and out-of-window pairs pass 0
    assign mag_next = (pair_fire && in_window) ? mag : '0;

    assign sum_wide = {1'b0, acc_reg} + (SUM_WIDTH + 1)'(sq_reg);
    assign sum_sat  = sum_wide[SUM_WIDTH] ? SUM_MAX : sum_wide[SUM_WIDTH-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_reg       <= '0;
            mag_end_reg   <= 1'b0;
            sq_reg        <= '0;
            sq_end_reg    <= 1'b0;
            acc_reg       <= '0;
            root_work_reg <= '0;
        end
        else
        begin
            mag_reg     <= mag_next;
            mag_end_reg <= pair_fire && end_of_vector;
            sq_reg      <= SQ_WIDTH'(mag_reg) * SQ_WIDTH'(mag_reg);
            sq_end_reg  <= mag_end_reg;
            if (sq_end_reg)
            begin
                root_work_reg <= sum_sat;
                acc_reg       <= '0;
            end
            else
            begin
                acc_reg <= sum_sat;
            end
        end
    end

    // one root bit per step, most significant digit pair first
    assign digit     = root_work_reg[{step_reg, 1'b0} +: 2];
    assign rem_shift = {rem_reg, digit};
    assign trial     = (REM_WIDTH + 2)'({root_reg, 2'b01});
    assign take      = (rem_shift >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (sq_end_reg)
        begin
            step_reg <= STEP_WIDTH'(ROOT_STEPS - 1);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.root_run)
        begin
            if (take)
            begin
                rem_reg  <= REM_WIDTH'(rem_shift - trial);
                root_reg <= {root_reg[DIST_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= REM_WIDTH'(rem_shift);
                root_reg <= {root_reg[DIST_WIDTH-2:0], 1'b0};
            end
            if (step_reg != '0)
            begin
                step_reg <= step_reg - 1'b1;
            end
        end
    end

    assign status.sum_done  = sq_end_reg;
    assign status.root_done = cmd.root_run && (step_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            distance_reg    <= root_reg;
            squared_sum_reg <= root_work_reg;
        end
    end

    assign distance    = distance_reg;
    assign squared_sum = squared_sum_reg;

endmodule

`default_nettype wire

[rtl/core/euclidean_distance_range.sv]
// Path: a vector result follows its last accepted pair through the magnitude
//   register, squaring stage, accumulate, 20 square root steps and output load.
// Throughput: one pair per cycle inside a vector; the last pair of a vector
//   stalls intake while the sum settles and the 20-step root runs,
//   longer while an earlier result still waits in the output register.
// Reset: rst_n clears the accumulator, the window to [0, 255] and all valids.
// ----------------------------------------------------------------------------
// euclidean_distance_range: windowed Euclidean distance
// Sums squared element differences over an index window and returns the sum
// with its floor square root at each end of vector.
// ----------------------------------------------------------------------------
`default_nettype none

module euclidean_distance_range
    import edr_pkg::*;
#(
    parameter int MAX_DIM       = 256,
    parameter int ELEMENT_WIDTH = 16
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    edr_cfg_if.sink      cfg,
    edr_pair_if.sink     pairs,
    edr_result_if.source results
);

    edr_cmd_t    cmd;
    edr_status_t status;
    logic        pair_fire;
    logic        cfg_fire;

    // configuration writes go straight into the window registers; always ready
    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid && cfg.ready;

    // a pair transaction completes when the controller is accumulating
    assign pair_fire = pairs.valid && pairs.ready;

    // Controller: hold intake after an end-of-vector pair, sequence the
    // root steps, then load the output register once it is free. The
    // output register parts both sides, so intake resumes while a result
    // still waits to be taken.
    edr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair_valid (pairs.valid),
        .pair_ready (pairs.ready),
        .pair_last  (pairs.end_of_vector),
        .out_valid  (results.valid),
        .out_ready  (results.ready),
        .status     (status),
        .cmd        (cmd)
    );

    // Datapath: difference magnitude, square, saturating accumulate,
    // then a restoring square root, one result bit per cycle.
    edr_datapath #(
        .MAX_DIM       (MAX_DIM),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .pair_fire     (pair_fire),
        .element_index (pairs.element_index),
        .left_element  (pairs.left_element),
        .right_element (pairs.right_element),
        .end_of_vector (pairs.end_of_vector),
        .cfg_fire      (cfg_fire),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .cmd           (cmd),
        .status        (status),
        .distance      (results.distance),
        .squared_sum   (results.squared_sum)
    );

endmodule

`default_nettype wire
